// ----- rtl/vrp_pkg.sv -----
// Package for the vertex rotate and project pipeline: widths, register indexes,
// divider stage types and the helper functions shared by the datapath.
// No dependencies.
package vrp_pkg;

   localparam int QUO_BITS = 25;   // quotient bits produced by the divider
   localparam int DVS_BITS = 24;   // divisor width (twice the view depth)
   localparam int DIV_STAGES = QUO_BITS;

   typedef enum logic [2:0] {
      CSR_COS_ANGLE    = 3'd0,
      CSR_SIN_ANGLE    = 3'd1,
      CSR_TRANSLATE_Z  = 3'd2,
      CSR_PROJ_X_SCALE = 3'd3,
      CSR_PROJ_Y_SCALE = 3'd4,
      CSR_HALF_WIDTH   = 3'd5,
      CSR_HALF_HEIGHT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DVS_BITS-1:0] rem;
      logic [QUO_BITS-1:0] low;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
      logic                ovf;
   } div_lane_type;

   typedef struct packed {
      logic                vld;
      div_lane_type        xl;
      div_lane_type        yl;
      logic [DVS_BITS-1:0] dvs;
      logic signed [22:0]  zv;
      logic                behind;
      logic                last;
   } div_stage_type;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   function automatic div_lane_type div_step(div_lane_type l, logic [DVS_BITS-1:0] d);
      div_lane_type      r;
      logic [DVS_BITS:0] t;
      logic [DVS_BITS:0] diff;
      r    = l;
      t    = {l.rem, l.low[QUO_BITS-1]};
      diff = t - {1'b0, d};
      r.low = {l.low[QUO_BITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         r.rem = diff[DVS_BITS-1:0];
         r.quo = {l.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         r.rem = t[DVS_BITS-1:0];
         r.quo = {l.quo[QUO_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [23:0] sat24(logic signed [26:0] v);
      logic [23:0] r;
      if (v > 27'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -27'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   function automatic logic [19:0] sat20(logic signed [22:0] v);
      logic [19:0] r;
      if (v > 23'sd524287) begin
         r = 20'h7FFFF;
      end else if (v < -23'sd524288) begin
         r = 20'h80000;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/vertex_rotate_project.sv -----
// Vertex rotate and project: each start transfer yields one result transfer after
// passing through the registered stages listed below;
// one vertex accepted every cycle, busy stays low.
// Six arithmetic stages, a 25-stage one-bit-per-stage divider, one output stage.
// Synchronous reset empties the pipeline and restores the control registers.
// Depends on vrp_pkg.
module vertex_rotate_project (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   output logic                  busy,
   input  logic signed [15:0]    req_vertex_x,
   input  logic signed [15:0]    req_vertex_y,
   input  logic signed [15:0]    req_vertex_z,
   input  logic                  req_last_vertex,
   output logic                  rsp_valid,
   output logic signed [23:0]    rsp_screen_x,
   output logic signed [23:0]    rsp_screen_y,
   output logic signed [19:0]    rsp_view_depth,
   output logic                  rsp_behind_camera,
   output logic                  rsp_last_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import vrp_pkg::*;

   logic signed [15:0] cos_ff, sin_ff, tz_ff;
   logic [15:0]        px_ff, py_ff;
   logic [11:0]        hw_ff, hh_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 16'sd16384;
         sin_ff <= 16'sd0;
         tz_ff  <= 16'sd4608;
         px_ff  <= 16'd12288;
         py_ff  <= 16'd16384;
         hw_ff  <= 12'd320;
         hh_ff  <= 12'd240;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COS_ANGLE:    cos_ff <= csr_data;
            CSR_SIN_ANGLE:    sin_ff <= csr_data;
            CSR_TRANSLATE_Z:  tz_ff  <= csr_data;
            CSR_PROJ_X_SCALE: px_ff  <= csr_data;
            CSR_PROJ_Y_SCALE: py_ff  <= csr_data;
            CSR_HALF_WIDTH:   hw_ff  <= csr_data[11:0];
            CSR_HALF_HEIGHT:  hh_ff  <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Stage 1: rotate about Y
   logic signed [32:0] x1_sum, z1_sum;
   logic signed [18:0] x1_ff, z1_ff;
   logic signed [15:0] y1_ff;
   logic               v1_ff, l1_ff;

   assign x1_sum = req_vertex_x * cos_ff + req_vertex_z * sin_ff + 33'sd8192;
   assign z1_sum = req_vertex_z * cos_ff - req_vertex_x * sin_ff + 33'sd8192;

   always_ff @(posedge clock) begin
      x1_ff <= x1_sum[32:14];
      z1_ff <= z1_sum[32:14];
      y1_ff <= req_vertex_y;
      l1_ff <= req_last_vertex;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_start && !busy;
      end
   end

   // Stage 2: rotate about X
   logic signed [35:0] y2_sum, z2_sum;
   logic signed [21:0] y2_ff, z2_ff;
   logic signed [18:0] x2_ff;
   logic               v2_ff, l2_ff;

   assign y2_sum = y1_ff * cos_ff - z1_ff * sin_ff + 36'sd8192;
   assign z2_sum = y1_ff * sin_ff + z1_ff * cos_ff + 36'sd8192;

   always_ff @(posedge clock) begin
      y2_ff <= y2_sum[35:14];
      z2_ff <= z2_sum[35:14];
      x2_ff <= x1_ff;
      l2_ff <= l1_ff;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // Stage 3: rotate about Z, translate depth
   logic signed [38:0] x3_sum, y3_sum;
   logic signed [24:0] x3_ff, y3_ff;
   logic signed [22:0] zv3_ff;
   logic               v3_ff, l3_ff;

   assign x3_sum = x2_ff * cos_ff - y2_ff * sin_ff + 39'sd8192;
   assign y3_sum = x2_ff * sin_ff + y2_ff * cos_ff + 39'sd8192;

   always_ff @(posedge clock) begin
      x3_ff  <= x3_sum[38:14];
      y3_ff  <= y3_sum[38:14];
      zv3_ff <= z2_ff + tz_ff;
      l3_ff  <= l2_ff;
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // Stage 4: projection scale
   logic signed [41:0] xp_sum, yp_sum;
   logic signed [27:0] xp_ff, yp_ff;
   logic signed [22:0] zv4_ff;
   logic               v4_ff, l4_ff;

   assign xp_sum = x3_ff * $signed({1'b0, px_ff}) + 42'sd8192;
   assign yp_sum = y3_ff * $signed({1'b0, py_ff}) + 42'sd8192;

   always_ff @(posedge clock) begin
      xp_ff  <= xp_sum[41:14];
      yp_ff  <= yp_sum[41:14];
      zv4_ff <= zv3_ff;
      l4_ff  <= l3_ff;
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   // Stage 5: scale by half viewport size
   logic signed [40:0] mx_ff, my_ff;
   logic signed [22:0] zv5_ff;
   logic               v5_ff, l5_ff;

   always_ff @(posedge clock) begin
      mx_ff  <= xp_ff * $signed({1'b0, hw_ff});
      my_ff  <= yp_ff * $signed({1'b0, hh_ff});
      zv5_ff <= zv4_ff;
      l5_ff  <= l4_ff;
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   // Stage 6: form dividends, fold negatives to ones' complement magnitude
   logic signed [50:0]  num_x, num_y;
   logic [49:0]         mag_x, mag_y;
   logic [DVS_BITS-1:0] dvs6;
   div_stage_type       div_in [0:DIV_STAGES];
   div_stage_type       div_ff [0:DIV_STAGES];

   assign num_x = $signed({mx_ff, 9'b0}) + zv5_ff;
   assign num_y = $signed({my_ff, 9'b0}) + zv5_ff;
   assign mag_x = num_x[49:0] ^ {50{num_x[50]}};
   assign mag_y = num_y[49:0] ^ {50{num_y[50]}};
   assign dvs6  = {zv5_ff[22:0], 1'b0};

   always_comb begin
      div_in[0].vld    = v5_ff;
      div_in[0].dvs    = dvs6;
      div_in[0].zv     = zv5_ff;
      div_in[0].behind = (zv5_ff <= 23'sd0);
      div_in[0].last   = l5_ff;
      div_in[0].xl.rem = mag_x[48:25];
      div_in[0].xl.low = mag_x[24:0];
      div_in[0].xl.quo = '0;
      div_in[0].xl.neg = num_x[50];
      div_in[0].xl.ovf = (mag_x[49:25] >= {1'b0, dvs6});
      div_in[0].yl.rem = mag_y[48:25];
      div_in[0].yl.low = mag_y[24:0];
      div_in[0].yl.quo = '0;
      div_in[0].yl.neg = num_y[50];
      div_in[0].yl.ovf = (mag_y[49:25] >= {1'b0, dvs6});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0] <= '0;
      end else begin
         div_ff[0] <= div_in[0];
      end
   end

   // Divider: one quotient bit per stage for both lanes
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_comb begin
         div_in[k]    = div_ff[k-1];
         div_in[k].xl = div_step(div_ff[k-1].xl, div_ff[k-1].dvs);
         div_in[k].yl = div_step(div_ff[k-1].yl, div_ff[k-1].dvs);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k] <= '0;
         end else begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Output stage: restore sign, add viewport offset, saturate, zero behind-camera results
   div_stage_type      fin;
   logic signed [26:0] tx, ty, sx_full, sy_full;
   logic signed [26:0] hw8, hh8;
   logic [23:0]        sx_in, sy_in;
   logic               rsp_valid_ff, rsp_behind_ff, rsp_last_ff;
   logic [23:0]        rsp_sx_ff, rsp_sy_ff;
   logic [19:0]        rsp_depth_ff;

   assign fin = div_ff[DIV_STAGES];
   assign hw8 = $signed({7'b0, hw_ff, 8'b0});
   assign hh8 = $signed({7'b0, hh_ff, 8'b0});
   assign tx  = fin.xl.neg ? $signed(~{2'b0, fin.xl.quo}) : $signed({2'b0, fin.xl.quo});
   assign ty  = fin.yl.neg ? $signed(~{2'b0, fin.yl.quo}) : $signed({2'b0, fin.yl.quo});
   assign sx_full = tx + hw8;
   assign sy_full = hh8 - ty;

   always_comb begin
      if (fin.behind) begin
         sx_in = '0;
      end else if (fin.xl.ovf) begin
         sx_in = fin.xl.neg ? 24'h800000 : 24'h7FFFFF;
      end else begin
         sx_in = sat24(sx_full);
      end
      if (fin.behind) begin
         sy_in = '0;
      end else if (fin.yl.ovf) begin
         sy_in = fin.yl.neg ? 24'h7FFFFF : 24'h800000;
      end else begin
         sy_in = sat24(sy_full);
      end
   end

   always_ff @(posedge clock) begin
      rsp_sx_ff     <= sx_in;
      rsp_sy_ff     <= sy_in;
      rsp_depth_ff  <= sat20(fin.zv);
      rsp_behind_ff <= fin.behind;
      rsp_last_ff   <= fin.last;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.vld;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_screen_x      = rsp_sx_ff;
   assign rsp_screen_y      = rsp_sy_ff;
   assign rsp_view_depth    = rsp_depth_ff;
   assign rsp_behind_camera = rsp_behind_ff;
   assign rsp_last_out      = rsp_last_ff;

`ifndef SYNTH
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_camera |-> rsp_screen_x == 24'sd0 && rsp_screen_y == 24'sd0)
      else $error("behind-camera result with nonzero screen position");

   a_behind_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_behind_camera == (rsp_view_depth <= 20'sd0))
      else $error("behind_camera disagrees with view depth");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      fin.vld && !fin.behind && !fin.xl.ovf |-> fin.xl.rem < fin.dvs)
      else $error("divider remainder not below divisor");
`endif

endmodule
